// ----- design/msr_pkg.sv -----
// ----------------------------------------------------------------------------
// msr_pkg: shared types and constants of the motor speed ramp
// widths, register codes, controller states and serial divider types
// ----------------------------------------------------------------------------
package msr_pkg;

  // field widths
  localparam int unsigned SPD_W    = 8;   // speed in whole rpm
  localparam int unsigned FRAC_W   = 8;   // q8.8 fraction bits
  localparam int unsigned RAMP_W   = 16;  // q8.8 ramp position
  localparam int unsigned MAG_W    = 19;  // step magnitude
  localparam int unsigned IDX_W    = 16;  // signed step counters
  localparam int unsigned CHG_W    = SPD_W + FRAC_W;
  localparam int unsigned PWM_W    = 12;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned RATE_W   = 11;
  localparam int unsigned TICK_W   = 14;
  localparam int unsigned REV_W    = 3;
  localparam int unsigned CFG_AW   = 4;
  localparam int unsigned CFG_DW   = 32;

  // serial divider sizing
  localparam int unsigned DIV_NW   = RATE_W + TICK_W + FRAC_W;
  localparam int unsigned DIV_DW   = MAG_W;
  localparam int unsigned DIV_CW   = $clog2(DIV_NW + 1);

  // default scales
  localparam int unsigned PWM_FULL_SCALE_DEF = 4095;
  localparam int unsigned RPM_FULL_SCALE_DEF = 200;

  // power loss timeouts in ms
  localparam int unsigned T_LONG_REV1  = 12000;
  localparam int unsigned T_SHORT_REV1 = 6000;
  localparam int unsigned T_LONG_OLD   = 5000;
  localparam int unsigned T_SHORT_OLD  = 2000;
  localparam int unsigned REV_FIRST    = 1;
  localparam int unsigned REV_NO_TIMEOUT = 4;

  localparam int unsigned MS_PER_S  = 1000;
  localparam int unsigned STEP_MAX  = 32767;
  localparam int unsigned MAG_MAX   = (1 << MAG_W) - 1;

  // reset values of the registers
  localparam int unsigned MIN_SPEED_RST = 0;
  localparam int unsigned RAMP_RATE_RST = 100;
  localparam int unsigned TICK_RST      = 500;
  localparam int unsigned BOARD_REV_RST = 4;

  typedef enum logic [1:0] {
    REG_MIN_SPEED   = 2'd0,
    REG_RAMP_RATE   = 2'd1,
    REG_TICK_PERIOD = 2'd2,
    REG_BOARD_REV   = 2'd3
  } msr_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MAG_START,
    ST_MAG_WAIT,
    ST_EVAL,
    ST_CNT_WAIT,
    ST_ADVANCE,
    ST_PWM_START,
    ST_PWM_WAIT,
    ST_DONE
  } msr_state_t;

  typedef struct packed {
    logic              start;
    logic [DIV_CW-1:0] iters;
    logic [DIV_NW-1:0] dividend;   // left aligned, msb first
    logic [DIV_DW-1:0] divisor;
  } msr_div_cmd_t;

  typedef struct packed {
    logic              done;
    logic [DIV_NW-1:0] quotient;
  } msr_div_rsp_t;

endpackage

// ----- design/msr_in_if.sv -----
// ----------------------------------------------------------------------------
// msr_in_if: speed request channel
// one word per control tick: request, power flag and two timestamps
// ----------------------------------------------------------------------------
interface msr_in_if;
  logic                        valid;
  logic                        ready;
  logic [msr_pkg::SPD_W-1:0]   request_rpm;
  logic                        power_present;
  logic [msr_pkg::TIME_W-1:0]  now_ms;
  logic [msr_pkg::TIME_W-1:0]  power_seen_ms;

  modport source (
    output valid, request_rpm, power_present, now_ms, power_seen_ms,
    input  ready
  );
  modport sink (
    input  valid, request_rpm, power_present, now_ms, power_seen_ms,
    output ready
  );
endinterface

// ----- design/msr_out_if.sv -----
// ----------------------------------------------------------------------------
// msr_out_if: drive result channel
// one word per tick: drive strobe, pwm code, speed and ramp flag
// ----------------------------------------------------------------------------
interface msr_out_if;
  logic                       valid;
  logic                       ready;
  logic                       drive_write;
  logic [msr_pkg::PWM_W-1:0]  pwm_value;
  logic [msr_pkg::SPD_W-1:0]  motor_speed;
  logic                       ramping;

  modport source (
    output valid, drive_write, pwm_value, motor_speed, ramping,
    input  ready
  );
  modport sink (
    input  valid, drive_write, pwm_value, motor_speed, ramping,
    output ready
  );
endinterface

// ----- design/msr_sdiv.sv -----
// ----------------------------------------------------------------------------
// msr_sdiv: bit-serial restoring divider
// one quotient bit per cycle, dividend shifted in msb first
// ----------------------------------------------------------------------------
module msr_sdiv (
  input  logic                  clk,
  input  logic                  rst_n,
  input  msr_pkg::msr_div_cmd_t cmd,
  output msr_pkg::msr_div_rsp_t rsp
);
  import msr_pkg::*;

  logic [DIV_NW-1:0] num_r, num_nxt;
  logic [DIV_NW-1:0] quo_r, quo_nxt;
  logic [DIV_DW-1:0] rem_r, rem_nxt;
  logic [DIV_DW-1:0] dvs_r, dvs_nxt;
  logic [DIV_CW-1:0] cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [DIV_DW:0]   trial;
  logic [DIV_DW:0]   diff;
  logic              ge;

  always_comb begin
    trial = {rem_r, num_r[DIV_NW-1]};
    diff  = trial - {1'b0, dvs_r};
    ge    = (trial >= {1'b0, dvs_r});

    num_nxt  = num_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;

    if (cmd.start) begin
      num_nxt  = cmd.dividend;
      quo_nxt  = '0;
      rem_nxt  = '0;
      dvs_nxt  = cmd.divisor;
      cnt_nxt  = cmd.iters;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      num_nxt = {num_r[DIV_NW-2:0], 1'b0};
      quo_nxt = {quo_r[DIV_NW-2:0], ge};
      rem_nxt = ge ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == DIV_CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    cnt_r <= cnt_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

// ----- design/motor_speed_ramp.sv -----
// ----------------------------------------------------------------------------
// motor_speed_ramp: linear speed ramp generator for a motor drive
// one word per control tick in, one drive word out, apb register port
// ----------------------------------------------------------------------------
// Each request word produces exactly one result word. The block works on one
// word at a time: a tick that changes nothing finishes without the divider,
// a tick that sets up a new ramp first runs the bit-serial divider for the
// step count, and every tick that issues a drive value runs it again for the
// pwm code (one quotient bit per cycle). All of these divisions share the
// one serial divider. A finished word sits in an output register, so the
// next request is taken while it waits. After reset and after each write of
// ramp_rate or tick_period_ms the step size is recomputed in the divider,
// during which no request is taken; register writes are taken at any time.
// Registers sit at byte addresses 0 (min_speed), 4 (ramp_rate),
// 8 (tick_period_ms) and 12 (board_revision), and read back their value.
// ----------------------------------------------------------------------------
module motor_speed_ramp #(
  parameter int unsigned PWM_FULL_SCALE = msr_pkg::PWM_FULL_SCALE_DEF,
  parameter int unsigned RPM_FULL_SCALE = msr_pkg::RPM_FULL_SCALE_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  msr_in_if.sink                      in_chan,
  msr_out_if.source                   out_chan,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [msr_pkg::CFG_AW-1:0]  paddr,
  input  logic [msr_pkg::CFG_DW-1:0]  pwdata,
  output logic [msr_pkg::CFG_DW-1:0]  prdata,
  output logic                        pready
);
  import msr_pkg::*;

  // derived sizes
  localparam int unsigned RMAX    = RPM_FULL_SCALE << FRAC_W;   // full scale in q8.8
  localparam int unsigned PSC_W   = $clog2(PWM_FULL_SCALE + 1);
  localparam int unsigned PROD_W  = RAMP_W + PSC_W;
  localparam int unsigned PDIV_W  = PROD_W - FRAC_W;
  localparam int unsigned SUM_W   = MAG_W + 2;

  localparam logic [SPD_W-1:0]  RPM_MAX  = SPD_W'(RPM_FULL_SCALE);
  localparam logic [RAMP_W-1:0] RAMP_MAX = RAMP_W'(RMAX);

  // --------------------------------------------------------------------------
  // register port
  // --------------------------------------------------------------------------
  logic [SPD_W-1:0]  min_speed_r;
  logic [RATE_W-1:0] ramp_rate_r;
  logic [TICK_W-1:0] tick_period_r;
  logic [REV_W-1:0]  board_rev_r;
  logic              stale_r, stale_nxt;   // step size needs recompute

  msr_reg_t cfg_idx;
  logic     cfg_wr;
  logic     cfg_step_wr;                   // write that changes the step size

  assign cfg_idx     = msr_reg_t'(paddr[CFG_AW-1:2]);
  assign cfg_wr      = psel & penable & pwrite;
  assign cfg_step_wr = cfg_wr && (cfg_idx == REG_RAMP_RATE || cfg_idx == REG_TICK_PERIOD);
  assign pready      = 1'b1;

  always_comb begin
    unique case (cfg_idx)
      REG_MIN_SPEED:   prdata = CFG_DW'(min_speed_r);
      REG_RAMP_RATE:   prdata = CFG_DW'(ramp_rate_r);
      REG_TICK_PERIOD: prdata = CFG_DW'(tick_period_r);
      REG_BOARD_REV:   prdata = CFG_DW'(board_rev_r);
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_speed_r   <= SPD_W'(MIN_SPEED_RST);
      ramp_rate_r   <= RATE_W'(RAMP_RATE_RST);
      tick_period_r <= TICK_W'(TICK_RST);
      board_rev_r   <= REV_W'(BOARD_REV_RST);
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_MIN_SPEED:   min_speed_r   <= pwdata[SPD_W-1:0];
        REG_RAMP_RATE:   ramp_rate_r   <= pwdata[RATE_W-1:0];
        REG_TICK_PERIOD: tick_period_r <= pwdata[TICK_W-1:0];
        REG_BOARD_REV:   board_rev_r   <= pwdata[REV_W-1:0];
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // state
  // --------------------------------------------------------------------------
  msr_state_t state_r, state_nxt;

  // captured request word
  logic [SPD_W-1:0] req_in_r, req_in_nxt;
  logic             pwr_in_r, pwr_in_nxt;
  logic             gt_long_r, gt_long_nxt;     // elapsed above long timeout
  logic             gt_short_r, gt_short_nxt;   // elapsed above short timeout

  // ramp state
  logic [SPD_W-1:0]         speed_now_r, speed_now_nxt;
  logic [SPD_W-1:0]         speed_tgt_r, speed_tgt_nxt;
  logic [RAMP_W-1:0]        ramp_r, ramp_nxt;
  logic [MAG_W-1:0]         smag_r, smag_nxt;   // step magnitude of current ramp
  logic                     sneg_r, sneg_nxt;   // ramp goes down
  logic signed [IDX_W-1:0]  idx_r, idx_nxt;
  logic signed [IDX_W-1:0]  total_r, total_nxt;
  logic [MAG_W-1:0]         mag_r, mag_nxt;     // step size from the registers

  // result of the current tick
  logic             wr_r, wr_nxt;
  logic             rmp_r, rmp_nxt;
  logic [PWM_W-1:0] pwm_r, pwm_nxt;

  // output register
  logic             out_valid_r, out_valid_nxt;
  logic             out_write_r, out_write_nxt;
  logic [PWM_W-1:0] out_pwm_r, out_pwm_nxt;
  logic [SPD_W-1:0] out_speed_r, out_speed_nxt;
  logic             out_ramping_r, out_ramping_nxt;

  msr_div_cmd_t div_cmd;
  msr_div_rsp_t div_rsp;

  msr_sdiv u_sdiv (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (div_cmd),
    .rsp   (div_rsp)
  );

  logic in_take;
  logic out_take;
  logic out_free;

  assign in_chan.ready = (state_r == ST_IDLE) && !stale_r && !cfg_step_wr;
  assign in_take       = in_chan.valid && in_chan.ready;
  assign out_take      = out_valid_r && out_chan.ready;
  assign out_free      = !out_valid_r || out_chan.ready;

  assign out_chan.valid       = out_valid_r;
  assign out_chan.drive_write = out_write_r;
  assign out_chan.pwm_value   = out_pwm_r;
  assign out_chan.motor_speed = out_speed_r;
  assign out_chan.ramping     = out_ramping_r;

  // --------------------------------------------------------------------------
  // power loss timing, checked when the word is taken
  // --------------------------------------------------------------------------
  logic [TIME_W-1:0] elapsed;
  logic [TIME_W-1:0] t_long;
  logic [TIME_W-1:0] t_short;

  always_comb begin
    elapsed = in_chan.now_ms - in_chan.power_seen_ms;   // wraps mod 2^32
    if (board_rev_r == REV_W'(REV_FIRST)) begin
      t_long  = TIME_W'(T_LONG_REV1);
      t_short = TIME_W'(T_SHORT_REV1);
    end else begin
      t_long  = TIME_W'(T_LONG_OLD);
      t_short = TIME_W'(T_SHORT_OLD);
    end
  end

  // --------------------------------------------------------------------------
  // tick evaluation: clamp, minimum, power loss, ramp setup
  // --------------------------------------------------------------------------
  logic [SPD_W-1:0] minv;
  logic [SPD_W-1:0] req_clamp;
  logic [SPD_W-1:0] req_min;
  logic [SPD_W-1:0] req_fin;      // request after power loss handling
  logic             force_stop;   // speed and target jump to the minimum
  logic [SPD_W-1:0] sn;
  logic [SPD_W-1:0] st;
  logic [SPD_W-1:0] eff;          // where the ramp heads
  logic [SPD_W-1:0] start_spd;    // where the ramp starts
  logic [SPD_W-1:0] diff_mag;
  logic             from_rest;

  always_comb begin
    minv      = (min_speed_r > RPM_MAX) ? RPM_MAX : min_speed_r;
    req_clamp = (req_in_r > RPM_MAX) ? RPM_MAX : req_in_r;
    req_min   = (req_clamp != '0 && req_clamp < minv) ? minv : req_clamp;

    req_fin    = req_min;
    force_stop = 1'b0;
    if (!pwr_in_r && req_min != '0) begin
      if (board_rev_r < REV_W'(REV_NO_TIMEOUT)) begin
        if (gt_long_r) begin
          req_fin    = '0;
          force_stop = 1'b1;
        end else if (gt_short_r) begin
          req_fin    = '0;   // ramp down
        end
      end else begin
        req_fin    = '0;
        force_stop = 1'b1;
      end
    end

    sn        = force_stop ? minv : speed_now_r;
    st        = force_stop ? minv : speed_tgt_r;
    from_rest = (req_fin != '0) && (sn == '0);
    eff       = (req_fin == '0) ? minv : req_fin;
    start_spd = from_rest ? minv : sn;
    // change and step always share a sign, so only the magnitude is divided
    diff_mag  = (eff >= start_spd) ? eff - start_spd : start_spd - eff;
  end

  // --------------------------------------------------------------------------
  // ramp advance: one q8.8 step, clamped to the speed range
  // --------------------------------------------------------------------------
  logic [IDX_W-1:0]       idx_inc;
  logic signed [SUM_W-1:0] ramp_sum;
  logic [RAMP_W-1:0]      ramp_step;
  logic                   idx_lt;

  always_comb begin
    idx_inc  = idx_r + 1'b1;
    idx_lt   = (idx_r < total_r);
    ramp_sum = sneg_r ? $signed(SUM_W'(ramp_r)) - $signed(SUM_W'(smag_r))
                      : $signed(SUM_W'(ramp_r)) + $signed(SUM_W'(smag_r));
    if (ramp_sum[SUM_W-1]) begin
      ramp_step = '0;
    end else if (ramp_sum > $signed(SUM_W'(RMAX))) begin
      ramp_step = RAMP_MAX;
    end else begin
      ramp_step = ramp_sum[RAMP_W-1:0];
    end
  end

  // serial divider operands
  logic [RATE_W+TICK_W-1:0] rt_prod;     // rate times tick period
  logic [PROD_W-1:0]        pwm_prod;    // ramp times pwm full scale
  logic [PDIV_W-1:0]        pwm_num;

  assign rt_prod  = ramp_rate_r * tick_period_r;
  assign pwm_prod = PROD_W'(ramp_r) * PROD_W'(PWM_FULL_SCALE);
  assign pwm_num  = pwm_prod[PROD_W-1:FRAC_W];

  // --------------------------------------------------------------------------
  // next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (stale_r) begin
          state_nxt = ST_MAG_START;
        end else if (in_take) begin
          state_nxt = ST_EVAL;
        end
      end
      ST_MAG_START: state_nxt = ST_MAG_WAIT;
      ST_MAG_WAIT: begin
        if (div_rsp.done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_EVAL: begin
        if (sn == req_fin) begin
          state_nxt = ST_DONE;
        end else if (st != req_fin) begin
          state_nxt = ST_CNT_WAIT;
        end else begin
          state_nxt = ST_ADVANCE;
        end
      end
      ST_CNT_WAIT: begin
        if (div_rsp.done) begin
          state_nxt = ST_ADVANCE;
        end
      end
      ST_ADVANCE: begin
        if (idx_lt || speed_now_r != speed_tgt_r) begin
          state_nxt = ST_PWM_START;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_PWM_START: state_nxt = ST_PWM_WAIT;
      ST_PWM_WAIT: begin
        if (div_rsp.done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // datapath and outputs
  // --------------------------------------------------------------------------
  always_comb begin
    req_in_nxt   = req_in_r;
    pwr_in_nxt   = pwr_in_r;
    gt_long_nxt  = gt_long_r;
    gt_short_nxt = gt_short_r;

    speed_now_nxt = speed_now_r;
    speed_tgt_nxt = speed_tgt_r;
    ramp_nxt      = ramp_r;
    smag_nxt      = smag_r;
    sneg_nxt      = sneg_r;
    idx_nxt       = idx_r;
    total_nxt     = total_r;
    mag_nxt       = mag_r;
    stale_nxt     = stale_r | cfg_step_wr;

    wr_nxt  = wr_r;
    rmp_nxt = rmp_r;
    pwm_nxt = pwm_r;

    out_valid_nxt   = out_valid_r & ~out_take;
    out_write_nxt   = out_write_r;
    out_pwm_nxt     = out_pwm_r;
    out_speed_nxt   = out_speed_r;
    out_ramping_nxt = out_ramping_r;

    div_cmd = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          req_in_nxt   = in_chan.request_rpm;
          pwr_in_nxt   = in_chan.power_present;
          gt_long_nxt  = elapsed > t_long;
          gt_short_nxt = elapsed > t_short;
        end
      end

      // step size = rate * tick * 256 / 1000
      ST_MAG_START: begin
        div_cmd.start    = 1'b1;
        div_cmd.iters    = DIV_CW'(DIV_NW);
        div_cmd.dividend = {rt_prod, {FRAC_W{1'b0}}};
        div_cmd.divisor  = DIV_DW'(MS_PER_S);
        stale_nxt        = cfg_step_wr;
      end

      ST_MAG_WAIT: begin
        if (div_rsp.done) begin
          if (div_rsp.quotient == '0) begin
            mag_nxt = MAG_W'(1);
          end else if (div_rsp.quotient > DIV_NW'(MAG_MAX)) begin
            mag_nxt = MAG_W'(MAG_MAX);
          end else begin
            mag_nxt = div_rsp.quotient[MAG_W-1:0];
          end
        end
      end

      ST_EVAL: begin
        speed_now_nxt = sn;
        speed_tgt_nxt = st;
        if (sn == req_fin) begin
          // idle tick, nothing issued
          wr_nxt  = 1'b0;
          rmp_nxt = 1'b0;
          pwm_nxt = '0;
        end else if (st != req_fin) begin
          // new target: set up the ramp and count its steps
          speed_tgt_nxt    = req_fin;
          idx_nxt          = from_rest ? {IDX_W{1'b1}} : '0;
          ramp_nxt         = {start_spd, {FRAC_W{1'b0}}};
          smag_nxt         = mag_r;
          sneg_nxt         = eff < sn;
          div_cmd.start    = 1'b1;
          div_cmd.iters    = DIV_CW'(CHG_W);
          div_cmd.dividend = DIV_NW'({diff_mag, {FRAC_W{1'b0}}}) << (DIV_NW - CHG_W);
          div_cmd.divisor  = mag_r;
        end
      end

      ST_CNT_WAIT: begin
        if (div_rsp.done) begin
          if (div_rsp.quotient > DIV_NW'(STEP_MAX)) begin
            total_nxt = IDX_W'(STEP_MAX);
          end else begin
            total_nxt = div_rsp.quotient[IDX_W-1:0];
          end
        end
      end

      ST_ADVANCE: begin
        if (idx_lt) begin
          idx_nxt = idx_inc;
          if (idx_inc != '0) begin
            ramp_nxt      = ramp_step;
            speed_now_nxt = ramp_step[RAMP_W-1:FRAC_W];
          end else begin
            // first tick from rest only lifts to the minimum
            speed_now_nxt = ramp_r[RAMP_W-1:FRAC_W];
          end
          wr_nxt  = 1'b1;
          rmp_nxt = 1'b1;
        end else if (speed_now_r != speed_tgt_r) begin
          // steps used up, snap to target
          ramp_nxt      = {speed_tgt_r, {FRAC_W{1'b0}}};
          speed_now_nxt = speed_tgt_r;
          wr_nxt        = 1'b1;
          rmp_nxt       = 1'b0;
        end else begin
          wr_nxt  = 1'b0;
          rmp_nxt = 1'b0;
          pwm_nxt = '0;
        end
      end

      // pwm = ramp * pwm scale / 256 / rpm scale
      ST_PWM_START: begin
        div_cmd.start    = 1'b1;
        div_cmd.iters    = DIV_CW'(PDIV_W);
        div_cmd.dividend = DIV_NW'(pwm_num) << (DIV_NW - PDIV_W);
        div_cmd.divisor  = DIV_DW'(RPM_FULL_SCALE);
      end

      ST_PWM_WAIT: begin
        if (div_rsp.done) begin
          pwm_nxt = div_rsp.quotient[PWM_W-1:0];
        end
      end

      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_write_nxt   = wr_r;
          out_pwm_nxt     = pwm_r;
          out_speed_nxt   = speed_now_r;
          out_ramping_nxt = rmp_r;
        end
      end

      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      stale_r     <= 1'b1;
      speed_now_r <= '0;
      speed_tgt_r <= '0;
      ramp_r      <= '0;
      idx_r       <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      stale_r     <= stale_nxt;
      speed_now_r <= speed_now_nxt;
      speed_tgt_r <= speed_tgt_nxt;
      ramp_r      <= ramp_nxt;
      idx_r       <= idx_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_in_r      <= req_in_nxt;
    pwr_in_r      <= pwr_in_nxt;
    gt_long_r     <= gt_long_nxt;
    gt_short_r    <= gt_short_nxt;
    smag_r        <= smag_nxt;
    sneg_r        <= sneg_nxt;
    mag_r         <= mag_nxt;
    wr_r          <= wr_nxt;
    rmp_r         <= rmp_nxt;
    pwm_r         <= pwm_nxt;
    out_write_r   <= out_write_nxt;
    out_pwm_r     <= out_pwm_nxt;
    out_speed_r   <= out_speed_nxt;
    out_ramping_r <= out_ramping_nxt;
  end

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  // commanded speed never leaves the speed range
  a_speed_range: assert property (@(posedge clk) disable iff (!rst_n)
    speed_now_r <= RPM_MAX)
    else $error("commanded speed above full scale");

  // ramp position stays within q8.8 full scale
  a_ramp_range: assert property (@(posedge clk) disable iff (!rst_n)
    ramp_r <= RAMP_MAX)
    else $error("ramp position above full scale");

  // step counter never runs past the step count
  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= total_r)
    else $error("step index beyond step count");

  // a word without a drive value carries a zero pwm code and no ramp flag
  a_idle_word: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_write_r) |-> (out_pwm_r == '0 && !out_ramping_r))
    else $error("idle word with drive data");

endmodule

// ----- verif/motor_speed_ramp_checker.sv -----
// ----------------------------------------------------------------------------
// motor_speed_ramp_checker: drive word scoreboard for the speed ramp
// watches the request, drive and register channels, predicts every drive
// word from its own copy of the ramp state and compares field by field
// ----------------------------------------------------------------------------
module motor_speed_ramp_checker
  import msr_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  msr_in_if                   in_mon,
  msr_out_if                  out_mon,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CFG_AW-1:0]   paddr,
  input  logic [CFG_DW-1:0]   pwdata,
  input  logic [CFG_DW-1:0]   prdata,
  input  logic                pready,
  output int                  fail_count,
  output int                  pending,
  output int                  ticks_seen,
  output int                  steps_seen,
  output int                  writes_seen
);

  localparam int RPM_FS   = int'(RPM_FULL_SCALE_DEF);
  localparam int PWM_FS   = int'(PWM_FULL_SCALE_DEF);
  localparam int RAMP_TOP = RPM_FS * 256;

  typedef struct packed {
    logic             drive_write;
    logic [PWM_W-1:0] pwm_value;
    logic [SPD_W-1:0] motor_speed;
    logic             ramping;
  } drive_word_t;

  // register copies
  logic [SPD_W-1:0]  min_speed_q;
  logic [RATE_W-1:0] ramp_rate_q;
  logic [TICK_W-1:0] tick_ms_q;
  logic [REV_W-1:0]  board_rev_q;

  // ramp state
  logic [SPD_W-1:0]        speed_now;
  logic [SPD_W-1:0]        speed_target;
  logic [RAMP_W:0]         ramp_pos;
  logic signed [MAG_W:0]   step_delta;
  logic signed [IDX_W-1:0] step_index;
  logic signed [IDX_W-1:0] step_total;

  drive_word_t drive_expect_q[$];
  int          words_checked;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    fail_count = fail_count + 1;
    if (fail_count <= 40)
      $display("mismatch after %0d drive words: %s is %0d, predicted %0d",
               words_checked, what, got, want);
  endtask

  function automatic logic [PWM_W-1:0] pwm_code(input logic [RAMP_W:0] v);
    longint p;
    p = longint'(v) * PWM_FS / RAMP_TOP;
    return p[PWM_W-1:0];
  endfunction

  function automatic logic [CFG_DW-1:0] reg_value(input msr_reg_t r);
    case (r)
      REG_MIN_SPEED:   return CFG_DW'(min_speed_q);
      REG_RAMP_RATE:   return CFG_DW'(ramp_rate_q);
      REG_TICK_PERIOD: return CFG_DW'(tick_ms_q);
      default:         return CFG_DW'(board_rev_q);
    endcase
  endfunction

  task automatic predict_tick(input logic [SPD_W-1:0] req_in, input logic pwr,
                              input logic [TIME_W-1:0] now, input logic [TIME_W-1:0] seen,
                              output drive_word_t r);
    logic [SPD_W-1:0]  minv;
    logic [SPD_W-1:0]  req;
    logic [SPD_W-1:0]  eff;
    logic [TIME_W-1:0] elapsed;
    logic [TIME_W-1:0] t_long;
    logic [TIME_W-1:0] t_short;
    longint            mag;
    int                change;
    int                q;
    int                d;
    int                nxt;
    r       = '0;
    minv    = (min_speed_q > RPM_FS) ? SPD_W'(RPM_FS) : min_speed_q;
    req     = (req_in > RPM_FS) ? SPD_W'(RPM_FS) : req_in;
    if (req != 0 && req < minv) req = minv;

    // power loss: timeouts on old boards, immediate stop otherwise
    if (!pwr && req != 0) begin
      if (board_rev_q < REV_NO_TIMEOUT) begin
        t_long  = (board_rev_q == REV_FIRST) ? T_LONG_REV1 : T_LONG_OLD;
        t_short = (board_rev_q == REV_FIRST) ? T_SHORT_REV1 : T_SHORT_OLD;
        elapsed = now - seen;
        if (elapsed > t_long) begin
          req          = '0;
          speed_now    = minv;
          speed_target = minv;
        end else if (elapsed > t_short) begin
          req = '0;
        end
      end else begin
        req          = '0;
        speed_now    = minv;
        speed_target = minv;
      end
    end

    if (speed_now != req) begin
      // new target: size and count the steps
      if (speed_target != req) begin
        mag = (longint'(ramp_rate_q) * longint'(tick_ms_q) * 256) / MS_PER_S;
        if (mag == 0) mag = 1;
        if (mag > MAG_MAX) mag = MAG_MAX;
        eff          = req;
        speed_target = req;
        step_index   = '0;
        ramp_pos     = {speed_now, 8'h00};
        if (req == 0) begin
          eff = minv;
        end else if (speed_now == 0) begin
          step_index = -1;
          ramp_pos   = {minv, 8'h00};
        end
        change     = int'(eff) * 256 - int'(ramp_pos);
        step_delta = (eff < speed_now) ? -mag : mag;
        d          = step_delta;
        q          = change / d;
        if (q > int'(STEP_MAX)) q = STEP_MAX;
        if (q < -32768) q = -32768;
        step_total = q[IDX_W-1:0];
      end

      if (step_index < step_total) begin
        step_index = step_index + 1;
        if (step_index != 0) begin
          d   = step_delta;
          nxt = int'(ramp_pos) + d;
          if (nxt < 0) nxt = 0;
          if (nxt > RAMP_TOP) nxt = RAMP_TOP;
          ramp_pos = nxt[RAMP_W:0];
        end
        speed_now     = ramp_pos[RAMP_W-1:FRAC_W];
        r.pwm_value   = pwm_code(ramp_pos);
        r.drive_write = 1'b1;
        r.ramping     = 1'b1;
      end else if (speed_now != speed_target) begin
        // steps used up: snap to the target
        ramp_pos      = {speed_target, 8'h00};
        speed_now     = speed_target;
        r.pwm_value   = pwm_code(ramp_pos);
        r.drive_write = 1'b1;
      end
    end
    r.motor_speed = speed_now;
  endtask

  always @(posedge clk) begin
    drive_word_t want;
    drive_word_t got;
    if (!rst_n) begin
      min_speed_q  <= SPD_W'(MIN_SPEED_RST);
      ramp_rate_q  <= RATE_W'(RAMP_RATE_RST);
      tick_ms_q    <= TICK_W'(TICK_RST);
      board_rev_q  <= REV_W'(BOARD_REV_RST);
      speed_now    <= '0;
      speed_target <= '0;
      ramp_pos     <= '0;
      step_delta   <= '0;
      step_index   <= '0;
      step_total   <= '0;
      drive_expect_q.delete();
      pending      <= 0;
    end else begin
      if (psel && penable && pready) begin
        if (pwrite) begin
          case (msr_reg_t'(paddr[3:2]))
            REG_MIN_SPEED:   min_speed_q = pwdata[SPD_W-1:0];
            REG_RAMP_RATE:   ramp_rate_q = pwdata[RATE_W-1:0];
            REG_TICK_PERIOD: tick_ms_q   = pwdata[TICK_W-1:0];
            REG_BOARD_REV:   board_rev_q = pwdata[REV_W-1:0];
          endcase
        end else if (prdata !== reg_value(msr_reg_t'(paddr[3:2]))) begin
          report_mismatch("register readback", prdata, reg_value(msr_reg_t'(paddr[3:2])));
        end
      end

      if (in_mon.valid && in_mon.ready) begin
        predict_tick(in_mon.request_rpm, in_mon.power_present, in_mon.now_ms,
                     in_mon.power_seen_ms, want);
        drive_expect_q.push_back(want);
        ticks_seen = ticks_seen + 1;
      end

      if (out_mon.valid && out_mon.ready) begin
        got.drive_write = out_mon.drive_write;
        got.pwm_value   = out_mon.pwm_value;
        got.motor_speed = out_mon.motor_speed;
        got.ramping     = out_mon.ramping;
        if (drive_expect_q.size() == 0) begin
          report_mismatch("unexpected drive word, pwm", got.pwm_value, 0);
        end else begin
          want = drive_expect_q.pop_front();
          if (got.drive_write !== want.drive_write)
            report_mismatch("drive_write", got.drive_write, want.drive_write);
          if (got.pwm_value !== want.pwm_value)
            report_mismatch("pwm_value", got.pwm_value, want.pwm_value);
          if (got.motor_speed !== want.motor_speed)
            report_mismatch("motor_speed", got.motor_speed, want.motor_speed);
          if (got.ramping !== want.ramping)
            report_mismatch("ramping", got.ramping, want.ramping);
          if (want.ramping) steps_seen = steps_seen + 1;
          if (want.drive_write) writes_seen = writes_seen + 1;
        end
        words_checked = words_checked + 1;
      end

      pending <= drive_expect_q.size();
    end
  end

endmodule

// ----- verif/motor_speed_ramp_tb.sv -----
// ----------------------------------------------------------------------------
// motor_speed_ramp_tb: top of the speed ramp testbench
// drives control ticks and register settings into the ramp generator with
// random gaps and output stalls; the checker beside the block predicts and
// compares every drive word, and this top gives the verdict
// ----------------------------------------------------------------------------
module motor_speed_ramp_tb;
  import msr_pkg::*;

  // watchdog limit for the whole run
  localparam longint RUN_LIMIT = 64'd20_000_000;
  localparam int     PHASE_TICKS = 155;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  int fail_count;
  int pending;
  int ticks_seen;
  int steps_seen;
  int writes_seen;
  int settings_run;

  // quiet-stretch counters, one per side
  int in_calm;
  int out_calm;

  msr_in_if  in_if ();
  msr_out_if out_if ();

  motor_speed_ramp i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  motor_speed_ramp_checker i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_if),
    .out_mon     (out_if),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .fail_count  (fail_count),
    .pending     (pending),
    .ticks_seen  (ticks_seen),
    .steps_seen  (steps_seen),
    .writes_seen (writes_seen)
  );

  always #10 clk = ~clk;

  // gap length: half zero, most short, a few long, with quiet stretches
  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm = calm - 1;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm = $urandom_range(20, 60);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // time since power was last seen: hug the old-board timeout boundaries
  function automatic logic [TIME_W-1:0] pick_elapsed();
    case ($urandom_range(0, 7))
      0:       return $urandom_range(0, 1999);
      1:       return $urandom_range(T_SHORT_OLD - 1, T_SHORT_OLD + 1);
      2:       return $urandom_range(T_LONG_OLD - 1, T_LONG_OLD + 1);
      3:       return $urandom_range(T_SHORT_REV1 - 1, T_SHORT_REV1 + 1);
      4:       return $urandom_range(T_LONG_REV1 - 1, T_LONG_REV1 + 1);
      5:       return $urandom;
      6:       return $urandom_range(T_SHORT_OLD + 2, T_LONG_OLD - 2);
      default: return $urandom_range(T_SHORT_REV1 + 2, 20000);
    endcase
  endfunction

  // speed target: standstill, below the minimum, clamped, full, ordinary
  function automatic logic [SPD_W-1:0] pick_target();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return $urandom_range(1, 30);
      2:       return $urandom_range(RPM_FULL_SCALE_DEF + 1, 255);
      3:       return RPM_FULL_SCALE_DEF;
      default: return $urandom_range(1, RPM_FULL_SCALE_DEF);
    endcase
  endfunction

  // one control tick; valid stays up across back-to-back words
  task automatic send_tick(input logic [SPD_W-1:0] req, input logic pwr,
                           input logic [TIME_W-1:0] now, input logic [TIME_W-1:0] seen);
    int gap;
    in_if.valid         <= 1'b1;
    in_if.request_rpm   <= req;
    in_if.power_present <= pwr;
    in_if.now_ms        <= now;
    in_if.power_seen_ms <= seen;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    gap = pick_gap(in_calm);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // stop sending and wait until every predicted drive word has come back
  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // apb write: setup then access, register taken when pready is high
  task automatic reg_write(input msr_reg_t r, input logic [CFG_DW-1:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // apb read; the checker compares prdata with its register copy
  task automatic reg_read(input msr_reg_t r);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {r, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // held targets so ramps run their course, power-loss episodes with a
  // growing outage, and some raw request noise
  task automatic random_ticks(input int count);
    logic [SPD_W-1:0]  target;
    logic [SPD_W-1:0]  req;
    logic              pwr;
    logic [TIME_W-1:0] now;
    logic [TIME_W-1:0] elapsed;
    int                hold;
    int                off_left;
    target   = '0;
    elapsed  = '0;
    hold     = 0;
    off_left = 0;
    for (int i = 0; i < count; i++) begin
      if (hold == 0) begin
        target = pick_target();
        hold   = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
      end
      hold = hold - 1;
      req  = ($urandom_range(0, 9) == 0) ? SPD_W'($urandom_range(0, 255)) : target;
      if (off_left == 0 && $urandom_range(0, 19) == 0) begin
        off_left = $urandom_range(1, 8);
        elapsed  = $urandom_range(0, 1500);
      end
      if (off_left > 0) begin
        // outage grows tick by tick, crossing the short and long timeouts
        pwr      = 1'b0;
        off_left = off_left - 1;
        elapsed  = elapsed + $urandom_range(300, 2500);
      end else if ($urandom_range(0, 29) == 0) begin
        pwr     = 1'b0;
        elapsed = pick_elapsed();
      end else begin
        pwr     = 1'b1;
        elapsed = pick_elapsed();
      end
      now = $urandom;
      send_tick(req, pwr, now, now - elapsed);
    end
  endtask

  // one register setting: program all four, read them back, then run ticks
  task automatic run_phase(input logic [SPD_W-1:0] min_v, input logic [RATE_W-1:0] rate_v,
                           input logic [TICK_W-1:0] tick_v, input logic [REV_W-1:0] rev_v,
                           input int count);
    drain();
    reg_write(REG_MIN_SPEED, CFG_DW'(min_v));
    reg_write(REG_RAMP_RATE, CFG_DW'(rate_v));
    reg_write(REG_TICK_PERIOD, CFG_DW'(tick_v));
    reg_write(REG_BOARD_REV, CFG_DW'(rev_v));
    reg_read(REG_MIN_SPEED);
    reg_read(REG_RAMP_RATE);
    reg_read(REG_TICK_PERIOD);
    reg_read(REG_BOARD_REV);
    random_ticks(count);
    settings_run = settings_run + 1;
  endtask

  // output side: ready runs broken by random stalls
  initial begin
    int gap;
    out_if.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      out_if.ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      gap = pick_gap(out_calm);
      if (gap > 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  initial begin
    rst_n               <= 1'b0;
    psel                <= 1'b0;
    penable             <= 1'b0;
    pwrite              <= 1'b0;
    paddr               <= '0;
    pwdata              <= '0;
    in_if.valid         <= 1'b0;
    in_if.request_rpm   <= '0;
    in_if.power_present <= 1'b0;
    in_if.now_ms        <= '0;
    in_if.power_seen_ms <= '0;
    settings_run = 1;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: 50 rpm steps, newer board
    send_tick(8'd0, 1'b1, 32'd1000, 32'd1000);          // idle tick, nothing issued
    repeat (4) send_tick(8'd100, 1'b1, 32'd2000, 32'd2000); // start from standstill
    repeat (2) send_tick(8'd255, 1'b1, 32'd3000, 32'd3000); // request clamped to full scale
    send_tick(8'd0, 1'b0, 32'd4000, 32'd0);             // power gone, zero request: no effect
    send_tick(8'd150, 1'b0, 32'd4500, 32'd4400);        // newer board stops at once
    repeat (3) send_tick(8'd60, 1'b1, 32'd5000, 32'd5000);
    repeat (2) send_tick(8'd0, 1'b1, 32'd6000, 32'd6000);   // ramp down to standstill

    // first revision: 6 s / 12 s timeouts, small requests raised to the minimum
    drain();
    reg_write(REG_MIN_SPEED, CFG_DW'(30));
    reg_write(REG_BOARD_REV, CFG_DW'(REV_FIRST));
    send_tick(8'd10, 1'b1, 32'd100, 32'd100);
    send_tick(8'd10, 1'b0, 32'd20000, 32'd20000 - T_SHORT_REV1);
    send_tick(8'd10, 1'b0, 32'd20000, 32'd20000 - T_SHORT_REV1 - 1);
    send_tick(8'd10, 1'b0, 32'd20000, 32'd20000 - T_LONG_REV1);
    send_tick(8'd10, 1'b0, 32'd20000, 32'd20000 - T_LONG_REV1 - 1);
    send_tick(8'd10, 1'b0, 32'd5, 32'd10);              // timestamp wrap: huge outage

    // revision zero behaves like the other old boards: 2 s / 5 s
    drain();
    reg_write(REG_BOARD_REV, CFG_DW'(0));
    send_tick(8'd100, 1'b1, 32'd0, 32'd0);
    send_tick(8'd100, 1'b0, 32'd9000, 32'd9000 - T_SHORT_OLD - 1);
    send_tick(8'd100, 1'b0, 32'd9000, 32'd9000 - T_LONG_OLD - 1);
    settings_run = settings_run + 2;

    // register extremes: saturated step, zero step with long ramps, minimum
    // above full scale, then ordinary and random settings
    run_phase(8'd0,   11'd2000, 14'd10000, 3'd1, PHASE_TICKS);
    run_phase(8'd200, 11'd1,    14'd1,     3'd2, PHASE_TICKS);
    run_phase(8'd255, 11'd0,    14'd0,     3'd0, PHASE_TICKS);
    run_phase(8'd20,  11'd300,  14'd100,   3'd3, PHASE_TICKS);
    run_phase(8'd10,  11'd2047, 14'd16383, 3'd7, PHASE_TICKS);
    run_phase(SPD_W'($urandom_range(0, 60)), RATE_W'($urandom_range(50, 2000)),
              TICK_W'($urandom_range(20, 1000)), REV_W'($urandom_range(0, 7)), PHASE_TICKS);
    run_phase(SPD_W'($urandom_range(0, 60)), RATE_W'($urandom_range(50, 2000)),
              TICK_W'($urandom_range(20, 1000)), REV_W'($urandom_range(0, 7)), PHASE_TICKS);
    run_phase(8'd5,   11'd100,  14'd500,   3'd4, PHASE_TICKS);

    // let the last word out, then leave room for anything stray
    drain();
    repeat (60) @(posedge clk);

    $display("run covered %0d ticks under %0d register settings: %0d ramp steps, %0d drive writes",
             ticks_seen, settings_run, steps_seen, writes_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("motor_speed_ramp test passed");
    end else begin
      $display("motor_speed_ramp test failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(RUN_LIMIT);
    $display("timeout with %0d drive words outstanding", pending);
    $display("motor_speed_ramp test failed");
    $finish;
  end

endmodule

// ----- files.f -----
design/msr_pkg.sv
design/msr_in_if.sv
design/msr_out_if.sv
design/msr_sdiv.sv
design/motor_speed_ramp.sv
verif/motor_speed_ramp_checker.sv
verif/motor_speed_ramp_tb.sv
